@@ hdl/llr_pkg.sv @@
// Shared types and constants for the line-assembling log ring.
package llr_pkg;

  localparam int BYTE_W  = 8;
  localparam int SEQ_W   = 32;
  localparam int LIMIT_W = 7;

  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMMIT,
    ST_RD_CHECK,
    ST_RD_LEN,
    ST_RD_FIRST,
    ST_RD_RUN,
    ST_RD_TAIL,
    ST_RD_SINGLE
  } state_t;

  typedef struct packed {
    logic              found;
    logic              has_char;
    logic [BYTE_W-1:0] char_out;
    logic              last;
  } emit_t;

endpackage

@@ hdl/llr_ram.sv @@
// Generic simple dual-port RAM with registered, enabled read.
module llr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/llr_ctrl.sv @@
// Sequencer and memories: staging buffer, line store, line lengths.
module llr_ctrl #(
  parameter int LINES     = 32,
  parameter int LINE_SIZE = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [llr_pkg::BYTE_W-1:0]    data_byte,
  input  logic [llr_pkg::SEQ_W-1:0]     seq,
  input  logic [llr_pkg::LIMIT_W-1:0]   read_limit,
  input  logic                          emit_ready,
  output logic                          emit_valid,
  output llr_pkg::emit_t                emit,
  output logic [llr_pkg::SEQ_W-1:0]     newest_seq,
  output logic [llr_pkg::SEQ_W-1:0]     oldest_seq
);
  import llr_pkg::*;

  localparam int PW          = $clog2(LINE_SIZE);
  localparam int SW          = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int DW          = $clog2(LINES + 1);
  localparam int XW          = DW + 1;
  localparam int STORE_DEPTH = LINES * (1 << PW);
  localparam int SAW         = $clog2(STORE_DEPTH);

  localparam logic [PW-1:0]    POS_MAX  = PW'(LINE_SIZE - 1);
  localparam logic [SW-1:0]    SLOT_MAX = SW'(LINES - 1);
  localparam logic [SEQ_W-1:0] LINES_W  = SEQ_W'(LINES);
  localparam logic [XW-1:0]    LINES_X  = XW'(LINES);

  state_t state, state_next;

  logic [SEQ_W-1:0]   line_count, line_count_next;
  logic [SW-1:0]      head_slot, head_slot_next;
  logic [PW-1:0]      stg_len, stg_len_next;
  logic [PW-1:0]      cp_idx, cp_idx_next;
  logic               hold_pend, hold_pend_next;
  logic [BYTE_W-1:0]  hold_byte, hold_byte_next;
  logic [SEQ_W-1:0]   rq_seq, rq_seq_next;
  logic [LIMIT_W-1:0] rq_limit, rq_limit_next;
  logic [SW-1:0]      rd_slot, rd_slot_next;
  logic [PW-1:0]      run_len, run_len_next;
  logic [PW-1:0]      pos, pos_next;
  logic [BYTE_W-1:0]  pend, pend_next;
  logic               single_found, single_found_next;

  // memory ports
  logic              stg_we, stg_re;
  logic [PW-1:0]     stg_waddr, stg_raddr;
  logic [BYTE_W-1:0] stg_wdata, stg_rdata;
  logic              st_we, st_re;
  logic [SAW-1:0]    st_waddr, st_raddr;
  logic [BYTE_W-1:0] st_rdata;
  logic              len_we, len_re;
  logic [SW-1:0]     len_waddr, len_raddr;
  logic [PW-1:0]     len_wdata, len_rdata;

  logic              accept;
  logic              hit;
  logic [SEQ_W-1:0]  seq_gap;
  logic [XW-1:0]     head_x, dist_x, slot_x;
  logic [LIMIT_W-1:0] cap;
  logic [PW-1:0]     len_eff;
  logic [PW:0]       pos_inc2;
  logic [SW-1:0]     head_adv;

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign newest_seq = line_count;
  assign oldest_seq = (line_count > LINES_W) ? (line_count - LINES_W) : '0;

  // slot of the line after the head; the count wrapping restarts at slot 0
  assign head_adv = (line_count == '1)       ? '0 :
                    (head_slot == SLOT_MAX)  ? '0 : head_slot + 1'b1;

  // window check and slot of rq_seq relative to the head
  assign hit    = (rq_limit != '0) && (rq_seq >= oldest_seq) && (rq_seq < line_count);
  assign seq_gap = line_count - rq_seq;
  assign head_x = XW'(head_slot);
  assign dist_x = XW'(seq_gap[DW-1:0]);
  assign slot_x = (head_x >= dist_x) ? (head_x - dist_x) : (head_x + LINES_X - dist_x);

  assign cap      = rq_limit - 1'b1;
  assign len_eff  = (LIMIT_W'(len_rdata) > cap) ? PW'(cap) : len_rdata;
  assign pos_inc2 = (PW + 1)'(pos) + (PW + 1)'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      line_count <= '0;
      head_slot  <= '0;
      stg_len    <= '0;
    end else begin
      state      <= state_next;
      line_count <= line_count_next;
      head_slot  <= head_slot_next;
      stg_len    <= stg_len_next;
    end
  end

  always_ff @(posedge clk) begin
    cp_idx       <= cp_idx_next;
    hold_pend    <= hold_pend_next;
    hold_byte    <= hold_byte_next;
    rq_seq       <= rq_seq_next;
    rq_limit     <= rq_limit_next;
    rd_slot      <= rd_slot_next;
    run_len      <= run_len_next;
    pos          <= pos_next;
    pend         <= pend_next;
    single_found <= single_found_next;
  end

  always_comb begin
    state_next        = state;
    line_count_next   = line_count;
    head_slot_next    = head_slot;
    stg_len_next      = stg_len;
    cp_idx_next       = cp_idx;
    hold_pend_next    = hold_pend;
    hold_byte_next    = hold_byte;
    rq_seq_next       = rq_seq;
    rq_limit_next     = rq_limit;
    rd_slot_next      = rd_slot;
    run_len_next      = run_len;
    pos_next          = pos;
    pend_next         = pend;
    single_found_next = single_found;

    stg_we    = 1'b0;
    stg_waddr = stg_len;
    stg_wdata = data_byte;
    stg_re    = 1'b0;
    stg_raddr = '0;
    st_we     = 1'b0;
    st_waddr  = SAW'({head_slot, cp_idx});
    st_re     = 1'b0;
    st_raddr  = SAW'({rd_slot, pos});
    len_we    = 1'b0;
    len_waddr = head_slot;
    len_wdata = stg_len;
    len_re    = 1'b0;
    len_raddr = slot_x[SW-1:0];

    emit_valid = 1'b0;
    emit       = '{found: 1'b1, has_char: 1'b1, char_out: pend, last: 1'b0};

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == KIND_READ) begin
            rq_seq_next   = seq;
            rq_limit_next = read_limit;
            state_next    = ST_RD_CHECK;
          end else if (data_byte == CH_CR) begin
            state_next = ST_IDLE;
          end else if (data_byte == CH_LF || stg_len >= POS_MAX) begin
            // commit the staged line; a full line keeps the byte for later
            len_we         = 1'b1;
            hold_pend_next = (data_byte != CH_LF);
            hold_byte_next = data_byte;
            if (stg_len == '0) begin
              line_count_next = line_count + 1'b1;
              head_slot_next  = head_adv;
            end else begin
              stg_re      = 1'b1;
              stg_raddr   = '0;
              cp_idx_next = '0;
              state_next  = ST_COMMIT;
            end
          end else begin
            stg_we       = 1'b1;
            stg_len_next = stg_len + 1'b1;
          end
        end
      end

      ST_COMMIT: begin
        st_we    = 1'b1;
        st_waddr = SAW'({head_slot, cp_idx});
        if (cp_idx == stg_len - 1'b1) begin
          line_count_next = line_count + 1'b1;
          head_slot_next  = head_adv;
          if (hold_pend) begin
            stg_we       = 1'b1;
            stg_waddr    = '0;
            stg_wdata    = hold_byte;
            stg_len_next = PW'(1);
          end else begin
            stg_len_next = '0;
          end
          state_next = ST_IDLE;
        end else begin
          stg_re      = 1'b1;
          stg_raddr   = cp_idx + 1'b1;
          cp_idx_next = cp_idx + 1'b1;
        end
      end

      ST_RD_CHECK: begin
        if (hit) begin
          len_re       = 1'b1;
          rd_slot_next = slot_x[SW-1:0];
          state_next   = ST_RD_LEN;
        end else begin
          single_found_next = 1'b0;
          state_next        = ST_RD_SINGLE;
        end
      end

      ST_RD_LEN: begin
        run_len_next = len_eff;
        if (len_eff == '0) begin
          single_found_next = 1'b1;
          state_next        = ST_RD_SINGLE;
        end else begin
          st_re      = 1'b1;
          st_raddr   = SAW'({rd_slot, PW'(0)});
          state_next = ST_RD_FIRST;
        end
      end

      ST_RD_FIRST: begin
        pend_next = st_rdata;
        if (st_rdata == '0) begin
          single_found_next = 1'b1;
          state_next        = ST_RD_SINGLE;
        end else if (run_len == PW'(1)) begin
          state_next = ST_RD_TAIL;
        end else begin
          pos_next   = PW'(1);
          st_re      = 1'b1;
          st_raddr   = SAW'({rd_slot, PW'(1)});
          state_next = ST_RD_RUN;
        end
      end

      ST_RD_RUN: begin
        // pend holds byte pos-1, st_rdata holds byte pos
        if (emit_ready) begin
          emit_valid = 1'b1;
          if (st_rdata == '0) begin
            emit.last  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            pend_next = st_rdata;
            pos_next  = pos + 1'b1;
            // fetch byte pos+1 while it is still inside the run
            if (pos_inc2 <= (PW + 1)'(run_len)) begin
              st_re    = 1'b1;
              st_raddr = SAW'({rd_slot, pos + 1'b1});
            end else begin
              state_next = ST_RD_TAIL;
            end
          end
        end
      end

      ST_RD_TAIL: begin
        if (emit_ready) begin
          emit_valid = 1'b1;
          emit.last  = 1'b1;
          state_next = ST_IDLE;
        end
      end

      ST_RD_SINGLE: begin
        if (emit_ready) begin
          emit_valid = 1'b1;
          emit       = '{found: single_found, has_char: 1'b0, char_out: '0, last: 1'b1};
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  llr_ram #(.WIDTH(BYTE_W), .DEPTH(LINE_SIZE), .AW(PW)) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (stg_wdata),
    .re    (stg_re),
    .raddr (stg_raddr),
    .rdata (stg_rdata)
  );

  llr_ram #(.WIDTH(BYTE_W), .DEPTH(STORE_DEPTH), .AW(SAW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (stg_rdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  llr_ram #(.WIDTH(PW), .DEPTH(LINES), .AW(SW)) u_lengths (
    .clk   (clk),
    .we    (len_we),
    .waddr (len_waddr),
    .wdata (len_wdata),
    .re    (len_re),
    .raddr (len_raddr),
    .rdata (len_rdata)
  );

endmodule

@@ hdl/llr_out.sv @@
// Output register stage for read results.
module llr_out (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      emit_valid,
  input  llr_pkg::emit_t            emit,
  input  logic [llr_pkg::SEQ_W-1:0] newest_in,
  input  logic [llr_pkg::SEQ_W-1:0] oldest_in,
  output logic                      emit_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      found,
  output logic                      has_char,
  output logic [llr_pkg::BYTE_W-1:0] char_out,
  output logic                      last,
  output logic [llr_pkg::SEQ_W-1:0] newest_seq,
  output logic [llr_pkg::SEQ_W-1:0] oldest_seq
);
  import llr_pkg::*;

  logic load;

  assign emit_ready = !out_valid || !out_stall;
  assign load       = emit_valid && emit_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      found      <= emit.found;
      has_char   <= emit.has_char;
      char_out   <= emit.char_out;
      last       <= emit.last;
      newest_seq <= newest_in;
      oldest_seq <= oldest_in;
    end
  end

endmodule

@@ hdl/line_assembling_log_ring.sv @@
// Line-assembling log ring: log bytes are gathered into lines (CR dropped, LF
// or a full line of LINE_SIZE-1 bytes commits) and kept in a ring of LINES
// slots addressed by a 32-bit running sequence count. Ordinary bytes, CR and an
// LF on an empty line transfer at one per cycle. Any other commit copies the
// staged line from the staging RAM into the line store, one byte per cycle, so
// an LF or an overflowing byte holds in_stall high for the whole copy. After a
// read transfer in_stall stays high through the lookup (window check, length
// RAM, first store byte) and then while the characters go out, one per cycle
// while out_stall is low, each coming from the single read port of the line
// store; a miss ends after the window check, an empty run after the length RAM
// (zero stored length or a buffer of one) or after the first store byte (a
// leading zero byte). in_stall stays high until the last result of a read is
// loaded into the output register, from which results reach out_valid.
// Results carry the sequence window (newest_seq, oldest_seq) seen at the time
// of the read. No clearing pass after reset: only committed slots are ever
// read.
module line_assembling_log_ring #(
  parameter int LINES     = 32,
  parameter int LINE_SIZE = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic [llr_pkg::BYTE_W-1:0]  data_byte,
  input  logic [llr_pkg::SEQ_W-1:0]   seq,
  input  logic [llr_pkg::LIMIT_W-1:0] read_limit,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic                        has_char,
  output logic [llr_pkg::BYTE_W-1:0]  char_out,
  output logic                        last,
  output logic [llr_pkg::SEQ_W-1:0]   newest_seq,
  output logic [llr_pkg::SEQ_W-1:0]   oldest_seq
);
  import llr_pkg::*;

  // sequencer to output stage
  logic             emit_valid;
  logic             emit_ready;
  emit_t            emit;
  logic [SEQ_W-1:0] newest_int;
  logic [SEQ_W-1:0] oldest_int;

  llr_ctrl #(.LINES(LINES), .LINE_SIZE(LINE_SIZE)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .seq        (seq),
    .read_limit (read_limit),
    .emit_ready (emit_ready),
    .emit_valid (emit_valid),
    .emit       (emit),
    .newest_seq (newest_int),
    .oldest_seq (oldest_int)
  );

  // result register: decouples the character stream from downstream stalls
  llr_out u_out (
    .clk        (clk),
    .rst        (rst),
    .emit_valid (emit_valid),
    .emit       (emit),
    .newest_in  (newest_int),
    .oldest_in  (oldest_int),
    .emit_ready (emit_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .has_char   (has_char),
    .char_out   (char_out),
    .last       (last),
    .newest_seq (newest_seq),
    .oldest_seq (oldest_seq)
  );

endmodule

@@ tb/tb_line_assembling_log_ring.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the line-assembling log ring: random-paced driver/monitor.
module tb_line_assembling_log_ring;
  import llr_pkg::*;

  localparam int LINES         = 32;
  localparam int LINE_SIZE     = 64;
  localparam int IDLE_PCT      = 38;    // chance per cycle that a side idles
  localparam int QUIET_LIMIT   = 3000;  // cycles with no transfer before giving up
  localparam int SETTLE_CYCLES = 200;   // covers a full-line commit and then some
  localparam int ITEM_TARGET   = 110;   // requests in a run, give or take

  // One host request as it goes over the request channel.
  typedef struct {
    logic               kind;
    logic [BYTE_W-1:0]  data;
    logic [SEQ_W-1:0]   seq;
    logic [LIMIT_W-1:0] limit;
    bit                 drain_first;  // hold off until every owed reply is back
  } log_req_t;

  // One reply beat of a read.
  typedef struct {
    logic              found;
    logic              has_char;
    logic [BYTE_W-1:0] ch;
    logic              last;
    logic [SEQ_W-1:0]  newest;
    logic [SEQ_W-1:0]  oldest;
  } line_chunk_t;

  logic               clk        = 1'b0;
  logic               rst        = 1'b1;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic               kind       = KIND_WRITE;
  logic [BYTE_W-1:0]  data_byte  = '0;
  logic [SEQ_W-1:0]   seq        = '0;
  logic [LIMIT_W-1:0] read_limit = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic               found;
  logic               has_char;
  logic [BYTE_W-1:0]  char_out;
  logic               last;
  logic [SEQ_W-1:0]   newest_seq;
  logic [SEQ_W-1:0]   oldest_seq;

  line_assembling_log_ring #(
    .LINES     (LINES),
    .LINE_SIZE (LINE_SIZE)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .data_byte  (data_byte),
    .seq        (seq),
    .read_limit (read_limit),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .has_char   (has_char),
    .char_out   (char_out),
    .last       (last),
    .newest_seq (newest_seq),
    .oldest_seq (oldest_seq)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Requests waiting to go out, and the replies the ring still owes us.
  log_req_t    host_ops[$];
  line_chunk_t read_replies[$];
  log_req_t    on_wire;          // request currently presented on the channel

  int ops_planned = 0;           // requests queued by the generator
  int ops_sent    = 0;           // requests transferred into the ring
  int fails       = 0;
  int quiet       = 0;

  // ---------------------------------------------------------------------------
  // Ring shadow: what the block should hold after each transferred request.
  // ---------------------------------------------------------------------------
  logic [BYTE_W-1:0]  kept_text [LINES][LINE_SIZE];
  logic [LIMIT_W-1:0] kept_len  [LINES];
  logic [BYTE_W-1:0]  draft_text[LINE_SIZE];
  int                 draft_len    = 0;
  logic [SEQ_W-1:0]   lines_logged = '0;

  // Bottom of the retained window; stays 0 until the ring has wrapped once.
  function automatic logic [SEQ_W-1:0] oldest_kept();
    return (lines_logged > LINES) ? lines_logged - LINES : '0;
  endfunction

  // Move the staged line into its ring slot and bump the sequence count.
  task automatic file_draft();
    int slot;
    int i;
    slot = lines_logged % LINES;
    for (i = 0; i < draft_len; i++) kept_text[slot][i] = draft_text[i];
    kept_len[slot] = LIMIT_W'(draft_len);
    lines_logged++;
    draft_len = 0;
  endtask

  // Replies carry the window as it stands when the read is taken.
  task automatic owe_reply(logic f, logic h, logic [BYTE_W-1:0] c, logic l);
    line_chunk_t r;
    r.found    = f;
    r.has_char = h;
    r.ch       = c;
    r.last     = l;
    r.newest   = lines_logged;
    r.oldest   = oldest_kept();
    read_replies.push_back(r);
  endtask

  task automatic apply_log_op(log_req_t op);
    int slot;
    int span;
    int n;
    int i;
    if (op.kind == KIND_WRITE) begin
      if (op.data == CH_LF) begin
        file_draft();
      end else if (op.data != CH_CR) begin
        // a byte landing on a full staging line pushes that line out first
        if (draft_len >= LINE_SIZE - 1) file_draft();
        draft_text[draft_len] = op.data;
        draft_len++;
      end
    end else if (op.limit == 0 || op.seq < oldest_kept() || op.seq >= lines_logged) begin
      owe_reply(1'b0, 1'b0, '0, 1'b1);
    end else begin
      slot = op.seq % LINES;
      span = int'(kept_len[slot]);
      if (int'(op.limit) - 1 < span) span = int'(op.limit) - 1;
      // run stops at stored length, caller's buffer, or an embedded zero
      n = 0;
      while (n < span && kept_text[slot][n] != 8'h00) n++;
      if (n == 0) begin
        owe_reply(1'b1, 1'b0, '0, 1'b1);
      end else begin
        for (i = 0; i < n; i++) owe_reply(1'b1, 1'b1, kept_text[slot][i], i == n - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Pacing: random idling on both sides, except for a calm stretch in the
  // middle of the run where both sides go flat out.
  // ---------------------------------------------------------------------------
  function automatic bit steady();
    return ops_sent >= 40 && ops_sent < 110;
  endfunction

  function automatic bit take_a_break();
    return !steady() && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Driver. A transfer at this edge is fed to the shadow before the next
  // request is considered, so a pending drain sees replies of that read too.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_log_op(on_wire);
        ops_sent <= ops_sent + 1;
      end
      if (!in_valid || !in_stall) begin
        if (host_ops.size() != 0 && !take_a_break() &&
            !(host_ops[0].drain_first && read_replies.size() != 0)) begin
          on_wire = host_ops.pop_front();
          in_valid   <= 1'b1;
          kind       <= on_wire.kind;
          data_byte  <= on_wire.data;
          seq        <= on_wire.seq;
          read_limit <= on_wire.limit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic match_field(string what, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
      fails++;
    end
  endtask

  // Monitor: every reply transfer is held against the oldest owed reply.
  always @(posedge clk) begin
    line_chunk_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (read_replies.size() == 0) begin
          $display("%0t: reply mismatch: expected none, actual f=%0b h=%0b c=%h l=%0b n=%h o=%h",
                   $time, found, has_char, char_out, last, newest_seq, oldest_seq);
          fails++;
        end else begin
          want = read_replies.pop_front();
          match_field("found", SEQ_W'(want.found), SEQ_W'(found));
          match_field("has_char", SEQ_W'(want.has_char), SEQ_W'(has_char));
          match_field("char_out", SEQ_W'(want.ch), SEQ_W'(char_out));
          match_field("last", SEQ_W'(want.last), SEQ_W'(last));
          match_field("newest_seq", want.newest, newest_seq);
          match_field("oldest_seq", want.oldest, oldest_seq);
        end
      end
      out_stall <= take_a_break();
    end
  end

  // Watchdog: too long with nothing moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb_line_assembling_log_ring: done, errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus generation. The generator tracks the line count on its own so
  // that reads can aim inside, at the edges of, and outside the window.
  // ---------------------------------------------------------------------------
  logic [SEQ_W-1:0] plan_lines = '0;
  int               plan_draft = 0;

  task automatic queue_op(logic k, logic [BYTE_W-1:0] b, logic [SEQ_W-1:0] s,
                          logic [LIMIT_W-1:0] lim, bit hold);
    log_req_t op;
    op.kind        = k;
    op.data        = b;
    op.seq         = s;
    op.limit       = lim;
    op.drain_first = hold;
    host_ops.push_back(op);
    ops_planned++;
    if (k == KIND_WRITE) begin
      if (b == CH_LF) begin
        plan_lines++;
        plan_draft = 0;
      end else if (b != CH_CR) begin
        if (plan_draft >= LINE_SIZE - 1) begin
          plan_lines++;
          plan_draft = 0;
        end
        plan_draft++;
      end
    end
  endtask

  // Unused fields of a transfer carry junk so they get exercised too.
  task automatic queue_byte(logic [BYTE_W-1:0] b);
    queue_op(KIND_WRITE, b, $urandom, LIMIT_W'($urandom_range(64)), 1'b0);
  endtask

  task automatic queue_read(logic [SEQ_W-1:0] s, logic [LIMIT_W-1:0] lim, bit hold);
    queue_op(KIND_READ, BYTE_W'($urandom_range(255)), s, lim, hold);
  endtask

  // Mostly printable text, some CRs mixed in, and now and then any byte.
  function automatic logic [BYTE_W-1:0] log_char();
    int r;
    r = $urandom_range(99);
    if (r < 75) return BYTE_W'($urandom_range(126, 32));
    if (r < 85) return CH_CR;
    return BYTE_W'($urandom_range(255));
  endfunction

  task automatic queue_line(int len);
    int i;
    for (i = 0; i < len; i++) queue_byte(log_char());
    queue_byte(CH_LF);
  endtask

  function automatic logic [SEQ_W-1:0] pick_seq();
    logic [SEQ_W-1:0] lo;
    int               r;
    lo = (plan_lines > LINES) ? plan_lines - LINES : '0;
    r  = $urandom_range(99);
    if (r < 60 && plan_lines != lo) return lo + $urandom_range(plan_lines - lo - 1);
    if (r < 68) return lo - 1;      // just below the window (all ones when lo is 0)
    if (r < 76) return plan_lines;  // next line, not yet written
    if (r < 80) return lo;
    return $urandom;
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return 7'd1;
    if (r < 25) return 7'd64;
    return LIMIT_W'($urandom_range(63, 2));
  endfunction

  initial begin
    int r;
    int i;

    // Directed: empty ring, empty line, buffer caps, misses on both sides
    // of the window, and zero bytes that cut a run short.
    queue_read(32'd0, 7'd5, 1'b0);        // nothing committed yet
    queue_byte(CH_LF);                    // line 0 is empty
    queue_read(32'd0, 7'd64, 1'b0);       // hit with no characters
    queue_byte(8'hFF);
    queue_byte(CH_CR);                    // dropped
    queue_byte(8'h01);
    queue_byte(8'h7F);
    queue_byte(CH_LF);                    // line 1 = FF 01 7F
    queue_read(32'd1, 7'd64, 1'b0);
    queue_read(32'd1, 7'd2, 1'b0);        // one character fits
    queue_read(32'd1, 7'd1, 1'b0);        // no room: empty run
    queue_read(32'd1, 7'd0, 1'b0);        // zero limit always misses
    queue_read(32'd2, 7'd64, 1'b0);       // at newest, not yet written
    queue_read('1, 7'd64, 1'b0);
    queue_byte(8'h55);
    queue_byte(8'h00);
    queue_byte(8'hAA);
    queue_byte(CH_LF);                    // line 2 stops after its first byte
    queue_read(32'd2, 7'd64, 1'b1);       // sender drains before this one
    queue_byte(8'h00);
    queue_byte(CH_LF);                    // line 3 opens with a zero
    queue_read(32'd3, 7'd10, 1'b0);

    // Full staging line: 63 bytes, a CR that must not commit, then a byte
    // that commits the full line and opens the next one.
    for (i = 0; i < LINE_SIZE - 1; i++) queue_byte(BYTE_W'($urandom_range(126, 32)));
    queue_byte(CH_CR);
    queue_byte(8'h5A);
    queue_byte(BYTE_W'($urandom_range(126, 32)));
    queue_byte(CH_LF);
    queue_read(plan_lines - 2, 7'd64, 1'b0);
    queue_read(plan_lines - 2, 7'd40, 1'b0);
    queue_read(plan_lines - 1, 7'd64, 1'b0);

    // Random: short lines and reads, some stray bytes, and just enough
    // commits to wrap the ring so the window starts to slide.
    while (ops_planned < ITEM_TARGET || plan_lines <= LINES + 2) begin
      r = $urandom_range(99);
      if (r < 70) queue_line($urandom_range(1));
      else if (r < 74) queue_byte(BYTE_W'($urandom_range(255)));
      else queue_read(pick_seq(), pick_limit(), $urandom_range(99) < 4);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (ops_sent != ops_planned) @(posedge clk);
    while (read_replies.size() != 0) @(posedge clk);
    // let any trailing commit finish and catch stray replies
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fails == 0) begin
      $display("tb_line_assembling_log_ring: done, clean");
    end else begin
      $display("tb_line_assembling_log_ring: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/llr_pkg.sv
hdl/llr_ram.sv
hdl/llr_ctrl.sv
hdl/llr_out.sv
hdl/line_assembling_log_ring.sv
tb/tb_line_assembling_log_ring.sv
